[rtl/core/conv3_pkg.sv]
// Shared constants and types for the 3x3 convolution line-detect core.
// No dependencies; used by conv3_linebuf, conv3_cell and the top level.
package conv3_pkg;

  localparam int PIX_W         = 8;
  localparam int PIX_MAX       = 255;
  localparam int DIM_W         = 10;
  localparam int ROW_W         = 9;
  localparam int MAX_HEIGHT    = 512;
  localparam int KROW_W        = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int DEF_MAX_WIDTH = 512;
  localparam int DEF_COEF_BITS = 8;
  localparam int DEF_IMAGE_DIM = 512;
  localparam logic [KROW_W-1:0] KERNEL_RESET = 24'hFF02FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  // per-stage load strobes for a window column cell
  typedef struct packed {
    logic shift;
    logic mul;
    logic sum;
  } cell_ctl_t;

endpackage

[rtl/core/conv3_linebuf.sv]
// Two line buffers (upper and middle image rows), one column per transaction.
// Registered read data with a bypass for a back-to-back hit on the same column.
// Depends on conv3_pkg.
module conv3_linebuf #(
  parameter int MAX_WIDTH = conv3_pkg::DEF_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 addr,
  input  logic [conv3_pkg::PIX_W-1:0]   px,
  output logic [conv3_pkg::PIX_W-1:0]   up_q,
  output logic [conv3_pkg::PIX_W-1:0]   mid_q
);

  logic [conv3_pkg::PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [conv3_pkg::PIX_W-1:0] up_mem  [MAX_WIDTH];

  logic [conv3_pkg::PIX_W-1:0] mid_q_r;
  logic [conv3_pkg::PIX_W-1:0] up_raw_r;
  logic [conv3_pkg::PIX_W-1:0] fwd_dat_r;
  logic                        fwd_r;
  logic                        wr_pend_r;
  logic [AW-1:0]               wr_addr_r;

  // middle row: read-first, new pixel written at the same address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_q_r      <= mid_mem[addr];
      mid_mem[addr] <= px;
    end
  end

  // upper row takes the old middle value in the cycle after the read
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      up_mem[wr_addr_r] <= mid_q_r;
    end
    if (rd_en) begin
      up_raw_r  <= up_mem[addr];
      fwd_r     <= wr_pend_r && (wr_addr_r == addr);
      fwd_dat_r <= mid_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= rd_en;
    end
    if (rd_en) begin
      wr_addr_r <= addr;
    end
  end

  assign mid_q = mid_q_r;
  assign up_q  = fwd_r ? fwd_dat_r : up_raw_r;

endmodule

[rtl/core/conv3_cell.sv]
// One window column cell: three pixels, three products, one column sum.
// Hands its pixel column to the left neighbor on every window shift. Depends on conv3_pkg.
module conv3_cell #(
  parameter int COEF_BITS = conv3_pkg::DEF_COEF_BITS,
  parameter int PW        = COEF_BITS + conv3_pkg::PIX_W + 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  conv3_pkg::cell_ctl_t                  ctl,
  input  logic [2:0][conv3_pkg::PIX_W-1:0]      col_in,
  input  logic [2:0][COEF_BITS-1:0]             coef,
  output logic [2:0][conv3_pkg::PIX_W-1:0]      col_out,
  output logic signed [PW+1:0]                  sum_out
);

  logic [2:0][conv3_pkg::PIX_W-1:0] col_r;
  logic signed [PW-1:0]             prod_r [3];
  logic signed [PW-1:0]             prod_nxt [3];
  logic signed [PW+1:0]             sum_r;
  logic signed [PW+1:0]             sum_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = $signed({1'b0, col_r[k]}) * $signed(coef[k]);
    end
    sum_nxt = (PW+2)'(prod_r[0]) + (PW+2)'(prod_r[1]) + (PW+2)'(prod_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctl.shift) begin
      col_r <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
    if (ctl.sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum_out = sum_r;

endmodule

[rtl/core/conv3x3_line_detect_core.sv]
// 3x3 line-detect convolution core: top level with counters, pipeline control and config.
// Instantiates conv3_linebuf and three conv3_cell; depends on conv3_pkg.
//
// Pixels enter in raster order at one per clock; in_tuser marks the first pixel of a
// frame. Every interior pixel (row and column both at least 2) yields one clamped
// 0..255 kernel response via the S1..S5 registers; border pixels yield nothing, and
// out_tlast marks the last interior pixel. The rate is one pixel per clock, set by
// the single read and write port of each line buffer and the three column cells that
// shift once per pixel. Back-pressure on the output only stalls the input once every
// pipeline stage is occupied. Line buffers hold no reset state and need no clearing
// pass; program sizes and kernel only while the stream is idle.
module conv3x3_line_detect_core #(
  parameter int MAX_WIDTH = conv3_pkg::DEF_MAX_WIDTH,
  parameter int COEF_BITS = conv3_pkg::DEF_COEF_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [conv3_pkg::KROW_W-1:0]        cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] pixel
  input  logic                                in_tuser,   // [0] frame_start
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] filtered
  output logic                                out_tlast   // frame_end
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > conv3_pkg::DIM_W) ? WW : conv3_pkg::DIM_W;
  localparam int PW   = COEF_BITS + conv3_pkg::PIX_W + 1;
  localparam int TW   = PW + 4;
  localparam int EXTW = conv3_pkg::KROW_W + 3 * COEF_BITS;
  localparam int RW   = conv3_pkg::ROW_W;
  localparam int DW   = conv3_pkg::DIM_W;
  localparam int PXW  = conv3_pkg::PIX_W;

  // configuration
  logic [DW-1:0]                     width_r, height_r;
  logic [2:0][conv3_pkg::KROW_W-1:0] kern_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(conv3_pkg::DEF_IMAGE_DIM);
      height_r <= DW'(conv3_pkg::DEF_IMAGE_DIM);
      kern_r   <= {3{conv3_pkg::KERNEL_RESET}};
    end else if (cfg_wr_en) begin
      case (conv3_pkg::cfg_reg_t'(cfg_index))
        conv3_pkg::REG_IMAGE_WIDTH:   width_r   <= cfg_data[DW-1:0];
        conv3_pkg::REG_IMAGE_HEIGHT:  height_r  <= cfg_data[DW-1:0];
        conv3_pkg::REG_KERNEL_TOP:    kern_r[0] <= cfg_data;
        conv3_pkg::REG_KERNEL_MIDDLE: kern_r[1] <= cfg_data;
        conv3_pkg::REG_KERNEL_BOTTOM: kern_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CMPW-1:0] w_raw, w_eff;
  logic [DW-1:0]   h_eff;

  always_comb begin
    w_raw = CMPW'(width_r);
    if (w_raw < CMPW'(3)) begin
      w_eff = CMPW'(3);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_r < DW'(3)) begin
      h_eff = DW'(3);
    end else if (height_r > DW'(conv3_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(conv3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // pipeline handshake: S1 line read, S2 window, S3 products, S4 column sums, S5 output
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic ready1, ready2, ready3, ready4, ready5;
  logic in_acc;

  assign ready5    = !out_valid_r || out_tready;
  assign ready4    = !v4_r || ready5;
  assign ready3    = !v3_r || ready4;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_tready = ready1;
  assign in_acc    = in_tvalid && ready1;

  // position counters
  logic [CW-1:0] col_r, col_nxt, c_cur;
  logic [RW-1:0] row_r, row_nxt, r_cur;
  logic          prod_cur, fend_cur;

  always_comb begin
    c_cur    = in_tuser ? '0 : col_r;
    r_cur    = in_tuser ? '0 : row_r;
    prod_cur = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
    fend_cur = (DW'(r_cur) == h_eff - DW'(1)) && (CMPW'(c_cur) == w_eff - CMPW'(1));
    if ((CMPW+1)'(c_cur) + (CMPW+1)'(1) >= (CMPW+1)'(w_eff)) begin
      col_nxt = '0;
      row_nxt = ((DW+1)'(r_cur) + (DW+1)'(1) >= (DW+1)'(h_eff)) ? '0 : r_cur + RW'(1);
    end else begin
      col_nxt = c_cur + CW'(1);
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // S1
  logic [PXW-1:0] px1_r, up1, mid1;
  logic           prod1_r, fend1_r;

  conv3_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (CW)
  ) u_linebuf (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .addr  (c_cur),
    .px    (in_tdata[PXW-1:0]),
    .up_q  (up1),
    .mid_q (mid1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (ready2) begin
      v1_r <= 1'b0;
    end
    if (in_acc) begin
      px1_r   <= in_tdata[PXW-1:0];
      prod1_r <= prod_cur;
      fend1_r <= fend_cur;
    end
  end

  // S2..S4 valid and tlast tracking
  logic fend2_r, fend3_r, fend4_r;
  logic go2, go3, go4, go5;

  assign go2 = v1_r && ready2;
  assign go3 = v2_r && ready3;
  assign go4 = v3_r && ready4;
  assign go5 = v4_r && ready5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go2) begin
        v2_r <= prod1_r;
      end else if (ready3) begin
        v2_r <= 1'b0;
      end
      if (go3) begin
        v3_r <= 1'b1;
      end else if (ready4) begin
        v3_r <= 1'b0;
      end
      if (go4) begin
        v4_r <= 1'b1;
      end else if (ready5) begin
        v4_r <= 1'b0;
      end
    end
    if (go2) fend2_r <= fend1_r;
    if (go3) fend3_r <= fend2_r;
    if (go4) fend4_r <= fend3_r;
  end

  // window column cells: cell 2 takes the new column, data moves toward cell 0
  logic [EXTW-1:0]                    kext [3];
  logic [2:0][2:0][PXW-1:0]           win;
  logic [2:0][2:0][PXW-1:0]           cin;
  logic [2:0][2:0][COEF_BITS-1:0]     coef;
  logic signed [PW+1:0]               csum [3];
  conv3_pkg::cell_ctl_t               ctl;

  assign ctl.shift = go2;
  assign ctl.mul   = go3;
  assign ctl.sum   = go4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kext[i] = EXTW'(kern_r[i]);
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        coef[j][i] = kext[i][j*COEF_BITS +: COEF_BITS];
      end
    end
    cin[2] = {px1_r, mid1, up1};
    cin[1] = win[2];
    cin[0] = win[1];
  end

  for (genvar j = 0; j < 3; j++) begin : g_cell
    conv3_cell #(
      .COEF_BITS (COEF_BITS),
      .PW        (PW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .col_in  (cin[j]),
      .coef    (coef[j]),
      .col_out (win[j]),
      .sum_out (csum[j])
    );
  end

  // S5: total, clamp, output register
  logic signed [TW-1:0] total;
  logic [PXW-1:0]       clamp;
  logic [PXW-1:0]       out_data_r;
  logic                 out_last_r;

  always_comb begin
    total = TW'(csum[0]) + TW'(csum[1]) + TW'(csum[2]);
    if (total < 0) begin
      clamp = '0;
    end else if (total > TW'(conv3_pkg::PIX_MAX)) begin
      clamp = PXW'(conv3_pkg::PIX_MAX);
    end else begin
      clamp = total[PXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go5) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (go5) begin
      out_data_r <= clamp;
      out_last_r <= fend4_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_sof_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (col_r == CW'(1) && row_r == '0))
    else $error("counters not restarted by frame start");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register is empty");

  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready3) |=> $stable(win))
    else $error("window moved while its transaction was stalled");

endmodule

[dv/testbench.sv]
// Testbench for conv3x3_line_detect_core: directed and random pixel streams with
// random idling on both sides, checked against a scoreboard with its own convolution model.
// Depends on conv3_pkg and the core RTL; stands alone otherwise.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH    = conv3_pkg::DEF_MAX_WIDTH;
  localparam int PIX_W         = conv3_pkg::PIX_W;
  localparam int DIM_W         = conv3_pkg::DIM_W;
  localparam int KROW_W        = conv3_pkg::KROW_W;
  localparam int COEF_W        = conv3_pkg::DEF_COEF_BITS;
  localparam int CFG_IDX_W     = conv3_pkg::CFG_IDX_W;
  localparam int MIN_DIM       = 3;
  localparam int TAPS          = 3;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PIXELS = 1700;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } response_t;

  class filter_scoreboard;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [KROW_W-1:0] kernel_row[TAPS];
    logic [PIX_W-1:0]  upper_line[LINE_DEPTH];
    logic [PIX_W-1:0]  middle_line[LINE_DEPTH];
    int                visits[LINE_DEPTH];
    logic [PIX_W-1:0]  win[TAPS][TAPS];
    int                col_pos;
    int                row_pos;
    response_t         expected_responses[$];
    int                mismatches;
    int                checked;
    int                frame_ends;

    function new();
      width_reg  = DIM_W'(conv3_pkg::DEF_IMAGE_DIM);
      height_reg = DIM_W'(conv3_pkg::DEF_IMAGE_DIM);
      foreach (kernel_row[i]) kernel_row[i] = conv3_pkg::KERNEL_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
        visits[i]      = 0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      checked    = 0;
      frame_ends = 0;
    endfunction

    function void set_reg(conv3_pkg::cfg_reg_t idx, logic [KROW_W-1:0] val);
      case (idx)
        conv3_pkg::REG_IMAGE_WIDTH:   width_reg = val[DIM_W-1:0];
        conv3_pkg::REG_IMAGE_HEIGHT:  height_reg = val[DIM_W-1:0];
        conv3_pkg::REG_KERNEL_TOP:    kernel_row[0] = val;
        conv3_pkg::REG_KERNEL_MIDDLE: kernel_row[1] = val;
        conv3_pkg::REG_KERNEL_BOTTOM: kernel_row[2] = val;
        default: ;
      endcase
    endfunction

    function int eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int eff_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > conv3_pkg::MAX_HEIGHT) return conv3_pkg::MAX_HEIGHT;
      return height_reg;
    endfunction

    // both line entries hold real pixels once a column was passed twice
    function bit lines_ready(int w);
      for (int i = 0; i < w; i++)
        if (visits[i] < 2) return 1'b0;
      return 1'b1;
    endfunction

    function int coefficient(int r, int k);
      logic signed [COEF_W-1:0] v;
      v = kernel_row[r][k*COEF_W +: COEF_W];
      return v;
    endfunction

    // one accepted pixel: advance window, line buffers and position
    function void take_pixel(logic [PIX_W-1:0] px, logic frame_start);
      int w, h, c, r, sum;
      response_t resp;
      w = eff_width();
      h = eff_height();
      if (frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos % LINE_DEPTH;
      r = row_pos;
      for (int i = 0; i < TAPS; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      if (visits[c] < 2) visits[c]++;
      if (r >= 2 && c >= 2) begin
        sum = 0;
        for (int i = 0; i < TAPS; i++)
          for (int j = 0; j < TAPS; j++)
            sum += int'(win[i][j]) * coefficient(i, j);
        if (sum > conv3_pkg::PIX_MAX) sum = conv3_pkg::PIX_MAX;
        if (sum < 0) sum = 0;
        resp.filtered  = sum[PIX_W-1:0];
        resp.frame_end = (r == h - 1) && (c == w - 1);
        expected_responses.push_back(resp);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_response(logic [PIX_W-1:0] filtered, logic frame_end);
      response_t want;
      if (expected_responses.size() == 0) begin
        $error("unexpected output transaction: filtered=%0d frame_end=%0b", filtered, frame_end);
        mismatches++;
        return;
      end
      want = expected_responses.pop_front();
      checked++;
      if (want.frame_end) frame_ends++;
      if (filtered !== want.filtered) begin
        $error("filtered: expected %0d, got %0d", want.filtered, filtered);
        mismatches++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KROW_W-1:0] cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // [7:0] pixel
  logic              in_tuser = 1'b0; // [0] frame_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // [7:0] filtered
  logic              out_tlast;       // frame_end

  filter_scoreboard sb;
  int  cycle_count = 0;
  int  stall_left = 0;
  int  stall_pct = 30;
  bit  burst = 1'b0;
  int  pixels_sent = 0;
  int  cfg_writes = 0;

  conv3x3_line_detect_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d outputs outstanding",
               cycle_count, sb.expected_responses.size());
      $display("** conv3x3_line_detect_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata, out_tlast);
  end

  // receiver back-pressure: short stalls mostly, a few long ones
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (burst) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PIX_W'(conv3_pkg::PIX_MAX);
      default: return PIX_W'($urandom());
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] random_kernel_row();
    logic [KROW_W-1:0] v;
    v = KROW_W'($urandom());
    case ($urandom_range(2))
      0: ;
      1: for (int k = 0; k < TAPS; k++)
           v[k*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(4)) - 2);
      default: for (int k = 0; k < TAPS; k++)
        case ($urandom_range(4))
          0: v[k*COEF_W +: COEF_W] = 8'h00;
          1: v[k*COEF_W +: COEF_W] = 8'h7F;
          2: v[k*COEF_W +: COEF_W] = 8'h80;
          3: v[k*COEF_W +: COEF_W] = 8'hFF;
          default: v[k*COEF_W +: COEF_W] = 8'h01;
        endcase
    endcase
    return v;
  endfunction

  function automatic int pick_width();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return $urandom_range(2);
    if (roll < 16) return $urandom_range(40, 17);
    return $urandom_range(16, 3);
  endfunction

  function automatic int pick_height();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return $urandom_range(2);
    if (roll < 16) return $urandom_range(24, 11);
    return $urandom_range(10, 3);
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] px, logic frame_start);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= frame_start;
    do @(posedge clk); while (!in_tready);
    sb.take_pixel(px, frame_start);
    pixels_sent++;
  endtask

  task automatic send_run(int count, bit mark_first, int extra_start);
    for (int i = 0; i < count; i++)
      send_pixel(random_pixel(), (i == 0 && mark_first) || i == extra_start);
  endtask

  // stop input, collect every outstanding output, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(conv3_pkg::cfg_reg_t idx, logic [KROW_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  // size registers take only the low bits; upper bits get junk
  task automatic write_size(conv3_pkg::cfg_reg_t idx, int dim);
    logic [KROW_W-1:0] val;
    val = KROW_W'($urandom());
    val[DIM_W-1:0] = DIM_W'(dim);
    write_reg(idx, val);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_kernel(logic [KROW_W-1:0] top, logic [KROW_W-1:0] mid,
                              logic [KROW_W-1:0] bot);
    write_reg(conv3_pkg::REG_KERNEL_TOP, top);
    write_reg(conv3_pkg::REG_KERNEL_MIDDLE, mid);
    write_reg(conv3_pkg::REG_KERNEL_BOTTOM, bot);
  endtask

  task automatic reconfigure(bit sizes_only);
    if ($urandom_range(1)) write_size(conv3_pkg::REG_IMAGE_WIDTH, pick_width());
    if ($urandom_range(1)) write_size(conv3_pkg::REG_IMAGE_HEIGHT, pick_height());
    if (!sizes_only) begin
      if ($urandom_range(1)) write_reg(conv3_pkg::REG_KERNEL_TOP, random_kernel_row());
      if ($urandom_range(1)) write_reg(conv3_pkg::REG_KERNEL_MIDDLE, random_kernel_row());
      if ($urandom_range(1)) write_reg(conv3_pkg::REG_KERNEL_BOTTOM, random_kernel_row());
    end
    cfg_release();
  endtask

  initial begin
    logic [PIX_W-1:0] ramp_pattern[9];
    int random_start, kind, w, h, extra;
    bit at_boundary;

    sb = new();
    ramp_pattern = '{8'd0, 8'd255, 8'd17, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd99};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smallest image, reset kernel
    write_size(conv3_pkg::REG_IMAGE_WIDTH, MIN_DIM);
    write_size(conv3_pkg::REG_IMAGE_HEIGHT, MIN_DIM);
    cfg_release();
    foreach (ramp_pattern[i]) send_pixel(ramp_pattern[i], i == 0);
    drain();
    // saturate high; counters wrapped, so no frame_start
    write_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    cfg_release();
    repeat (9) send_pixel(PIX_W'(conv3_pkg::PIX_MAX), 1'b0);
    drain();
    // saturate low
    write_kernel(24'h808080, 24'h808080, 24'h808080);
    cfg_release();
    for (int i = 0; i < 9; i++) send_pixel(PIX_W'(conv3_pkg::PIX_MAX), i == 0);

    random_start = pixels_sent;
    at_boundary = 1'b1;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      burst = ($urandom_range(3) == 0);
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 70;
        default: stall_pct = 25;
      endcase
      if ($urandom_range(2) == 0) begin
        drain();
        reconfigure(1'b0);
        at_boundary = 1'b0;
      end
      w = sb.eff_width();
      h = sb.eff_height();
      kind = $urandom_range(99);
      if (kind < 70) begin
        extra = ($urandom_range(24) == 0) ? $urandom_range(w * h - 1, 1) : -1;
        send_run(w * h, !at_boundary || $urandom_range(1), extra);
        at_boundary = (extra < 0);
      end else if (kind < 85) begin
        // frame cut short, next one restarts
        send_run($urandom_range(w * h - 1, 1), 1'b1, -1);
        at_boundary = 1'b0;
      end else begin
        // sizes change under a running frame; rows wider than any filled one restart
        send_run($urandom_range(w * h - 1, 1), 1'b1, -1);
        drain();
        reconfigure(1'b1);
        send_run($urandom_range(2 * sb.eff_width() * sb.eff_height(), 1),
                 !sb.lines_ready(sb.eff_width()), -1);
        at_boundary = 1'b0;
      end
    end

    drain();
    $display("Sent %0d pixels (%0d in random frames) with %0d register writes,",
             pixels_sent, pixels_sent - random_start, cfg_writes);
    $display("widths up to 40 and heights up to 24, sizes below 3 clamped.");
    $display("Checked %0d filtered outputs, %0d of them frame ends.", sb.checked, sb.frame_ends);
    if (sb.mismatches == 0) begin
      $display("** conv3x3_line_detect_core: PASSED **");
    end else begin
      $display("** conv3x3_line_detect_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/conv3_pkg.sv
rtl/core/conv3_linebuf.sv
rtl/core/conv3_cell.sv
rtl/core/conv3x3_line_detect_core.sv
dv/testbench.sv
